// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RHSM_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rhsm assertion failed");

// Next-cycle implication.
`define RHSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rhsm assertion failed");

`endif

// ===== hw/rtl/rhsm_pkg.sv =====
// ----------------------------------------------------------------------------
// rhsm_pkg
// Types, constants and modular helpers of the rolling hash matcher.
// ----------------------------------------------------------------------------
package rhsm_pkg;

  localparam int unsigned MAX_PATTERN = 64;
  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  localparam longint unsigned HMOD = 64'd1000000007;
  localparam logic [29:0] M30 = 30'(HMOD);
  localparam logic [30:0] M31 = 31'(HMOD);
  localparam logic [30:0] M2X = 31'(2 * HMOD);
  // Offset that keeps a negative weight product positive.
  localparam logic signed [38:0] PROD_BIAS = 39'(96 * HMOD);

  localparam logic [1:0] MODE_RESTART = 2'd0;
  localparam logic [1:0] MODE_PATTERN = 2'd1;
  localparam logic [1:0] MODE_TEXT    = 2'd2;

  typedef enum logic [1:0] {
    KIND_RESTART,
    KIND_PATTERN,
    KIND_TEXT
  } item_kind_e;

  typedef struct packed {
    item_kind_e        kind;
    logic              has_pat;
    logic              first;
    logic              win;
    logic              full;
    logic [IDX_W-1:0]  inj;
    logic [31:0]       start;
  } item_t;

  typedef logic [29:0] fold_tbl_t [128];

  function automatic fold_tbl_t fold_table();
    fold_tbl_t tbl;
    for (int i = 0; i < 128; i++) begin
      tbl[i] = 30'((longint'(i) << 30) % HMOD);
    end
    return tbl;
  endfunction

  // Residue of 2^30 times each upper-bit value.
  localparam fold_tbl_t FOLD_TBL = fold_table();

  // Reduces a value below 128 * 2^30 modulo HMOD.
  function automatic logic [29:0] fold37(input logic [36:0] v);
    logic [30:0] s;
    s = {1'b0, v[29:0]} + {1'b0, FOLD_TBL[v[36:30]]};
    if (s >= M2X) begin
      s = s - M2X;
    end else if (s >= M31) begin
      s = s - M31;
    end
    return s[29:0];
  endfunction

  function automatic logic [29:0] mul31(input logic [29:0] x);
    logic [34:0] y;
    y = {x, 5'b0} - {5'b0, x};
    return fold37({2'b0, y});
  endfunction

  function automatic logic [29:0] addmod(input logic [29:0] a, input logic [29:0] b);
    logic [30:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= M31) begin
      s = s - M31;
    end
    return s[29:0];
  endfunction

  function automatic logic [29:0] submod(input logic [29:0] a, input logic [29:0] b);
    logic [30:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = ({1'b0, a} + M31) - {1'b0, b};
    end
    return s[29:0];
  endfunction

endpackage

// ===== hw/rtl/rhsm_if.sv =====
// ----------------------------------------------------------------------------
// rhsm_if
// Valid/ready channels of the rolling hash matcher: characters in, matches out.
// ----------------------------------------------------------------------------
interface rhsm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [6:0] letter;

  modport source (output valid, output mode, output letter, input ready);
  modport sink   (input valid, input mode, input letter, output ready);
endinterface

interface rhsm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] match_start;

  modport source (output valid, output match_start, input ready);
  modport sink   (input valid, input match_start, output ready);
endinterface

// ===== hw/rtl/rhsm_cell.sv =====
// ----------------------------------------------------------------------------
// rhsm_cell
// One slot of the prefix delay chain: loads the new prefix or its neighbour.
// ----------------------------------------------------------------------------
module rhsm_cell (
  input  logic        clk_i,
  input  logic        shift_i,
  input  logic        load_new_i,
  input  logic [29:0] new_i,
  input  logic [29:0] next_i,
  output logic [29:0] value_o
);

  logic [29:0] value_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      value_q <= load_new_i ? new_i : next_i;
    end
  end

  assign value_o = value_q;

endmodule

// ===== hw/rtl/rhsm_wmul.sv =====
// ----------------------------------------------------------------------------
// rhsm_wmul
// Two-stage weight times power product, reduced modulo the hash prime.
// ----------------------------------------------------------------------------
module rhsm_wmul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  rhsm_pkg::item_t     tag_i,
  input  logic [6:0]          letter_i,
  input  logic [29:0]         pow_i,
  output logic                valid_o,
  output rhsm_pkg::item_t     tag_o,
  output logic [29:0]         term_o
);

  logic signed [7:0]  wt;
  logic signed [38:0] prod;
  logic signed [38:0] biased;

  logic               vld1_q;
  rhsm_pkg::item_t    tag1_q;
  logic [36:0]        v1_q;
  logic               vld2_q;
  rhsm_pkg::item_t    tag2_q;
  logic [29:0]        term2_q;

  // Signed weight letter - 96 lies in -96..31, so the biased product is positive.
  assign wt     = $signed({1'b0, letter_i}) - 8'sd96;
  assign prod   = wt * $signed({1'b0, pow_i});
  assign biased = prod + rhsm_pkg::PROD_BIAS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (adv_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tag1_q  <= tag_i;
      v1_q    <= biased[36:0];
      tag2_q  <= tag1_q;
      term2_q <= rhsm_pkg::fold37(v1_q);
    end
  end

  assign valid_o = vld2_q;
  assign tag_o   = tag2_q;
  assign term_o  = term2_q;

endmodule

// ===== hw/rtl/rolling_hash_substring_match.sv =====
// ----------------------------------------------------------------------------
// rolling_hash_substring_match
// Rolling-hash substring matcher, base 31 modulo 1000000007, over a stream.
// ----------------------------------------------------------------------------
// Usage: each input beat carries a mode and a letter. A restart beat clears
// the search, pattern beats build the pattern hash (up to 64 letters, and only
// before the first text beat), and text beats extend the text prefix hash.
// Whenever the hash of the last pattern-length text letters equals the pattern
// hash, one output beat carries the zero-based start of that window. Only the
// hashes are compared. Mode 3 beats and pattern beats after text are dropped.
// Throughput is one beat per cycle unless stalled; the prefix accumulator and
// the delay chain each take one step per cycle as the pipeline advances. A match
// goes via the product stages and the s3 and s4 stages to the output register.
// After reset the block is empty and ready at once; there is no clearing pass.
// When the receiver stalls, input beats keep being accepted until a further
// match reaches the end of the pipeline, and only then does ready fall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rolling_hash_substring_match (
  input  logic              clk_i,
  input  logic              rst_ni,
  rhsm_in_if.sink           in_i,
  rhsm_out_if.source        out_o
);

  localparam int unsigned NCELL = rhsm_pkg::MAX_PATTERN;
  localparam int unsigned LW    = rhsm_pkg::LEN_W;
  localparam int unsigned IW    = rhsm_pkg::IDX_W;

  // Front end: counters and running powers, updated as beats are accepted.
  logic [31:0]             cnt_q;
  logic [LW-1:0]           len_q;
  logic [29:0]             tp_q;
  logic [29:0]             pp_q;
  logic                    take;
  logic                    acc;
  logic                    adv;
  rhsm_pkg::item_t         tag_in;
  logic [LW-1:0]           len_m1;
  logic [29:0]             pow;

  // Back end stages.
  logic                    s2_vld;
  rhsm_pkg::item_t         s2_tag;
  logic [29:0]             s2_term;
  logic [29:0]             ph_q;
  logic [29:0]             p_q;
  logic [29:0]             sp_q;
  logic [29:0]             prefix_new;
  logic [29:0]             sp_cur;
  logic                    s2_text;
  logic                    chain_shift;
  logic [29:0]             cell_val [NCELL];
  logic [29:0]             cell_next [NCELL];

  logic                    s3_vld_q;
  logic [29:0]             s3_prefix_q;
  logic [29:0]             s3_older_q;
  logic [29:0]             s3_sp_q;
  logic [31:0]             s3_start_q;

  logic                    s4_vld_q;
  logic [29:0]             s4_window_q;
  logic [29:0]             s4_sp_q;
  logic [31:0]             s4_start_q;
  logic                    s4_hit;

  logic                    out_vld_q;
  logic [31:0]             out_start_q;

  // The pipeline only halts when a new match would collide with a held one.
  assign s4_hit = s4_vld_q && (s4_window_q == s4_sp_q);
  assign adv    = !(s4_hit && out_vld_q && !out_o.ready);

  assign in_i.ready = adv;
  assign acc        = in_i.valid && adv;

  assign len_m1 = len_q - LW'(1);

  always_comb begin
    take           = 1'b0;
    tag_in.kind    = rhsm_pkg::KIND_RESTART;
    tag_in.has_pat = (len_q != '0);
    tag_in.first   = (cnt_q == '0);
    tag_in.win     = (len_q != '0) && (cnt_q >= 32'(len_m1));
    tag_in.full    = (cnt_q >= 32'(len_q));
    tag_in.inj     = IW'(len_m1);
    tag_in.start   = cnt_q - 32'(len_m1);
    case (in_i.mode)
      rhsm_pkg::MODE_RESTART: begin
        take = 1'b1;
      end
      rhsm_pkg::MODE_PATTERN: begin
        take        = (cnt_q == '0) && (len_q < LW'(NCELL));
        tag_in.kind = rhsm_pkg::KIND_PATTERN;
      end
      rhsm_pkg::MODE_TEXT: begin
        take        = (cnt_q != '1);
        tag_in.kind = rhsm_pkg::KIND_TEXT;
      end
      default: begin
        take = 1'b0;
      end
    endcase
  end

  assign pow = (tag_in.kind == rhsm_pkg::KIND_TEXT) ? tp_q : pp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      len_q <= '0;
      tp_q  <= 30'd1;
      pp_q  <= 30'd1;
    end else if (acc && take) begin
      case (tag_in.kind)
        rhsm_pkg::KIND_RESTART: begin
          cnt_q <= '0;
          len_q <= '0;
          tp_q  <= 30'd1;
          pp_q  <= 30'd1;
        end
        rhsm_pkg::KIND_PATTERN: begin
          len_q <= len_q + LW'(1);
          pp_q  <= rhsm_pkg::mul31(pp_q);
        end
        rhsm_pkg::KIND_TEXT: begin
          cnt_q <= cnt_q + 32'd1;
          tp_q  <= rhsm_pkg::mul31(tp_q);
        end
        default: begin
          cnt_q <= cnt_q;
        end
      endcase
    end
  end

  // Weight times power, two registered stages.
  rhsm_wmul u_wmul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (acc && take),
    .tag_i    (tag_in),
    .letter_i (in_i.letter),
    .pow_i    (pow),
    .valid_o  (s2_vld),
    .tag_o    (s2_tag),
    .term_o   (s2_term)
  );

  // Accumulation stage: pattern hash, prefix hash and the shifted pattern hash.
  // The shifted pattern hash is seeded from the pattern hash on the first text
  // beat and then advances by one power of 31 per window.
  assign s2_text     = s2_vld && (s2_tag.kind == rhsm_pkg::KIND_TEXT);
  assign prefix_new  = rhsm_pkg::addmod(p_q, s2_term);
  assign sp_cur      = s2_tag.first ? ph_q : sp_q;
  assign chain_shift = adv && s2_text && s2_tag.has_pat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= '0;
      p_q  <= '0;
      sp_q <= '0;
    end else if (adv && s2_vld) begin
      case (s2_tag.kind)
        rhsm_pkg::KIND_RESTART: begin
          ph_q <= '0;
          p_q  <= '0;
          sp_q <= '0;
        end
        rhsm_pkg::KIND_PATTERN: begin
          ph_q <= rhsm_pkg::addmod(ph_q, s2_term);
        end
        rhsm_pkg::KIND_TEXT: begin
          p_q  <= prefix_new;
          sp_q <= s2_tag.win ? rhsm_pkg::mul31(sp_cur) : sp_cur;
        end
        default: begin
          p_q <= p_q;
        end
      endcase
    end
  end

  // Delay chain of prefix values. The newest prefix enters at the cell that
  // sits pattern-length minus one places from the head, so the head cell always
  // holds the prefix from exactly pattern-length text beats earlier.
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    if (k == NCELL - 1) begin : g_tail
      assign cell_next[k] = prefix_new;
    end else begin : g_body
      assign cell_next[k] = cell_val[k+1];
    end
    rhsm_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (chain_shift),
      .load_new_i (s2_tag.inj == IW'(k)),
      .new_i      (prefix_new),
      .next_i     (cell_next[k]),
      .value_o    (cell_val[k])
    );
  end

  // Only text beats that close a full window travel further.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        s3_vld_q <= s2_text && s2_tag.win;
        s4_vld_q <= s3_vld_q;
      end
      if (adv && s4_hit) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_prefix_q <= prefix_new;
      s3_older_q  <= s2_tag.full ? cell_val[0] : '0;
      s3_sp_q     <= sp_cur;
      s3_start_q  <= s2_tag.start;
      s4_window_q <= rhsm_pkg::submod(s3_prefix_q, s3_older_q);
      s4_sp_q     <= s3_sp_q;
      s4_start_q  <= s3_start_q;
    end
    if (adv && s4_hit) begin
      out_start_q <= s4_start_q;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.match_start = out_start_q;

  `RHSM_ASSERT_NEXT(a_restart_clears, in_i.valid && in_i.ready && (in_i.mode == rhsm_pkg::MODE_RESTART), (cnt_q == '0) && (len_q == '0))
  `RHSM_ASSERT(a_stall_on_collision, s4_hit && out_vld_q && !out_o.ready, !in_i.ready)
  `RHSM_ASSERT_NEXT(a_hash_reduced, adv && s2_vld, (p_q < rhsm_pkg::M30) && (ph_q < rhsm_pkg::M30) && (sp_q < rhsm_pkg::M30))

endmodule
